// ===== hw/rtl/mbtc_pkg.sv =====
// Shared constants, codes and controller/datapath structs for the
// Modbus TCP read-holding-registers client. No dependencies.
package mbtc_pkg;

  localparam int MAX_REGS_DEF = 16;
  localparam int HDR_LEN      = 8;
  localparam int HDR_AW       = 3;
  localparam int REQ_LEN      = 12;
  localparam int RUN_LIMIT    = 16;

  localparam logic [7:0] MBAP_LEN_LO    = 8'h06;
  localparam logic [7:0] FUNC_READ_HOLD = 8'h03;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RX_BYTE = 1'b1;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [1:0] ST_BAD_LEN  = 2'd0;
  localparam logic [1:0] ST_TID      = 2'd1;
  localparam logic [1:0] ST_FUNC     = 2'd2;
  localparam logic [1:0] ST_COUNT    = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       start_req;
    logic       store_byte;
    logic       clear_wait;
    logic       load_req;
    logic       load_fail;
    logic [1:0] fail_code;
    logic       word_start;
    logic       rd_word;
    logic       load_word;
  } cmd_t;

  typedef struct packed {
    logic is_req;
    logic awaiting;
    logic hdr_phase;
    logic hdr_fail;
    logic overrun;
    logic body_last;
    logic tid_ok;
    logic func_ok;
    logic count_ok;
    logic cnt_zero;
    logic req_last;
    logic word_last;
  } sts_t;

endpackage

// ===== hw/rtl/mbtc_req_if.sv =====
// Input channel: request or received byte item, valid/ready handshake.
// Depends on nothing.
interface mbtc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  unit_id;
  logic [15:0] start_address;
  logic [4:0]  reg_count;
  logic [7:0]  rx_byte;

  modport source (output valid, opcode, unit_id, start_address, reg_count, rx_byte,
                  input ready);
  modport sink (input valid, opcode, unit_id, start_address, reg_count, rx_byte,
                output ready);
endinterface

// ===== hw/rtl/mbtc_res_if.sv =====
// Output channel: request byte, register word or failure status item.
// Depends on nothing.
interface mbtc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, kind, tx_byte, reg_index, reg_value, status, last,
                  input ready);
  modport sink (input valid, kind, tx_byte, reg_index, reg_value, status, last,
                output ready);
endinterface

// ===== hw/rtl/mbtc_datapath.sv =====
// Datapath: item latch, transaction state, header registers, word RAM,
// request byte mux and result register. Uses mbtc_pkg.
module mbtc_datapath #(
  parameter int MAX_REGS = mbtc_pkg::MAX_REGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mbtc_pkg::cmd_t     cmd,
  output mbtc_pkg::sts_t     sts,
  input  logic               opcode,
  input  logic [7:0]         unit_id,
  input  logic [15:0]        start_address,
  input  logic [4:0]         reg_count,
  input  logic [7:0]         rx_byte,
  output logic [1:0]         kind,
  output logic [7:0]         tx_byte,
  output logic [3:0]         reg_index,
  output logic [15:0]        reg_value,
  output logic [1:0]         status,
  output logic               last
);

  localparam int BODY_MAX = 1 + 2 * MAX_REGS;
  localparam int POS_W    = $clog2(mbtc_pkg::HDR_LEN + BODY_MAX + 1);
  localparam int AW       = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  // latched item
  logic        op_q;
  logic [7:0]  unit_q;
  logic [15:0] addr_q;
  logic [4:0]  count_q;
  logic [7:0]  rx_q;

  logic [15:0]      next_tid;
  logic [15:0]      exp_tid;
  logic [4:0]       exp_cnt;
  logic             awaiting;
  logic [POS_W-1:0] rx_pos;
  logic [3:0]       req_k;
  logic [3:0]       widx;

  logic [7:0]  hdr [mbtc_pkg::HDR_LEN];
  logic [7:0]  body0;
  logic [7:0]  hi_byte;
  logic [15:0] wmem [MAX_REGS];
  logic [15:0] rdata;

  logic [15:0]      len16;
  logic [15:0]      blen16;
  logic             len_bad;
  logic [POS_W-1:0] bpos;
  logic [7:0]       b0_val;
  logic [7:0]       req_byte;
  logic [AW-1:0]    wr_addr;

  assign len16   = {hdr[4], hdr[5]};
  assign blen16  = len16 - 16'd2;
  assign len_bad = (len16 < 16'd3) || (len16 > 16'(BODY_MAX + 2));
  assign bpos    = rx_pos - POS_W'(mbtc_pkg::HDR_LEN);
  assign b0_val  = (bpos == '0) ? rx_q : body0;
  assign wr_addr = AW'((bpos >> 1) - POS_W'(1));

  always_comb begin
    sts.is_req    = (op_q == mbtc_pkg::OP_REQUEST);
    sts.awaiting  = awaiting;
    sts.hdr_phase = (rx_pos < POS_W'(mbtc_pkg::HDR_LEN));
    sts.hdr_fail  = (rx_pos == POS_W'(mbtc_pkg::HDR_LEN - 1)) && len_bad;
    sts.overrun   = len_bad || (16'(bpos) >= blen16);
    sts.body_last = (16'(bpos) + 16'd1 == blen16);
    sts.tid_ok    = ({hdr[0], hdr[1]} == exp_tid);
    sts.func_ok   = (hdr[7] == mbtc_pkg::FUNC_READ_HOLD);
    sts.count_ok  = (b0_val == {2'b00, exp_cnt, 1'b0}) &&
                    (blen16 == {10'd0, exp_cnt, 1'b1}) &&
                    (exp_cnt <= 5'(mbtc_pkg::RUN_LIMIT));
    sts.cnt_zero  = (exp_cnt == '0);
    sts.req_last  = (req_k == 4'(mbtc_pkg::REQ_LEN - 1));
    sts.word_last = (5'(widx) + 5'd1 == exp_cnt);
  end

  always_comb begin
    case (req_k)
      4'd0:    req_byte = exp_tid[15:8];
      4'd1:    req_byte = exp_tid[7:0];
      4'd5:    req_byte = mbtc_pkg::MBAP_LEN_LO;
      4'd6:    req_byte = unit_q;
      4'd7:    req_byte = mbtc_pkg::FUNC_READ_HOLD;
      4'd8:    req_byte = addr_q[15:8];
      4'd9:    req_byte = addr_q[7:0];
      4'd11:   req_byte = {3'b000, count_q};
      default: req_byte = 8'h00;
    endcase
  end

  // payload latches, header and body stores, word read and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= opcode;
      unit_q  <= unit_id;
      addr_q  <= start_address;
      count_q <= reg_count;
      rx_q    <= rx_byte;
    end
    if (cmd.store_byte) begin
      if (sts.hdr_phase) begin
        hdr[rx_pos[mbtc_pkg::HDR_AW-1:0]] <= rx_q;
      end else if (bpos == '0) begin
        body0 <= rx_q;
      end else if (bpos[0]) begin
        hi_byte <= rx_q;
      end else begin
        wmem[wr_addr] <= {hi_byte, rx_q};
      end
    end
    if (cmd.rd_word) begin
      rdata <= wmem[AW'(widx)];
    end
    if (cmd.load_req) begin
      kind      <= mbtc_pkg::KIND_TX;
      tx_byte   <= req_byte;
      reg_index <= '0;
      reg_value <= '0;
      status    <= '0;
      last      <= sts.req_last;
    end else if (cmd.load_fail) begin
      kind      <= mbtc_pkg::KIND_FAIL;
      tx_byte   <= '0;
      reg_index <= '0;
      reg_value <= '0;
      status    <= cmd.fail_code;
      last      <= 1'b1;
    end else if (cmd.load_word) begin
      kind      <= mbtc_pkg::KIND_WORD;
      tx_byte   <= '0;
      reg_index <= widx;
      reg_value <= rdata;
      status    <= '0;
      last      <= sts.word_last;
    end
  end

  // transaction state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      next_tid <= 16'd1;
      exp_tid  <= '0;
      exp_cnt  <= '0;
      awaiting <= 1'b0;
      rx_pos   <= '0;
      req_k    <= '0;
      widx     <= '0;
    end else begin
      if (cmd.start_req) begin
        next_tid <= next_tid + 16'd1;
        exp_tid  <= next_tid;
        exp_cnt  <= count_q;
        awaiting <= 1'b1;
        rx_pos   <= '0;
        req_k    <= '0;
      end else if (cmd.clear_wait) begin
        // end of a run wins over the byte count
        awaiting <= 1'b0;
        rx_pos   <= '0;
      end else if (cmd.store_byte) begin
        rx_pos <= rx_pos + POS_W'(1);
      end
      if (cmd.load_req) begin
        req_k <= req_k + 4'd1;
      end
      if (cmd.word_start) begin
        widx <= '0;
      end else if (cmd.load_word) begin
        widx <= widx + 4'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/mbtc_ctrl.sv =====
// Controller FSM: input handshake, per-item sequencing and output valid.
// Uses mbtc_pkg; drives mbtc_datapath through cmd_t.
module mbtc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mbtc_pkg::sts_t sts,
  output mbtc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_REQ, S_FAIL, S_RD, S_WORD} state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] code;
  logic [1:0] code_next;
  logic       can_load;
  logic       load_any;

  assign in_ready = (state == S_IDLE);
  assign can_load = !out_valid || out_ready;
  assign load_any = cmd.load_req || cmd.load_fail || cmd.load_word;

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    cmd.fail_code = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        if (sts.is_req) begin
          cmd.start_req = 1'b1;
          state_next    = S_REQ;
        end else if (!sts.awaiting) begin
          state_next = S_IDLE;
        end else if (sts.hdr_phase) begin
          cmd.store_byte = 1'b1;
          if (sts.hdr_fail) begin
            cmd.clear_wait = 1'b1;
            code_next      = mbtc_pkg::ST_BAD_LEN;
            state_next     = S_FAIL;
          end
        end else if (sts.overrun) begin
          cmd.clear_wait = 1'b1;
          code_next      = mbtc_pkg::ST_BAD_LEN;
          state_next     = S_FAIL;
        end else begin
          cmd.store_byte = 1'b1;
          if (sts.body_last) begin
            cmd.clear_wait = 1'b1;
            if (!sts.tid_ok) begin
              code_next  = mbtc_pkg::ST_TID;
              state_next = S_FAIL;
            end else if (!sts.func_ok) begin
              code_next  = mbtc_pkg::ST_FUNC;
              state_next = S_FAIL;
            end else if (!sts.count_ok) begin
              code_next  = mbtc_pkg::ST_COUNT;
              state_next = S_FAIL;
            end else if (!sts.cnt_zero) begin
              cmd.word_start = 1'b1;
              state_next     = S_RD;
            end
          end
        end
      end
      S_REQ: begin
        if (can_load) begin
          cmd.load_req = 1'b1;
          if (sts.req_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FAIL: begin
        if (can_load) begin
          cmd.load_fail = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_word = 1'b1;
        state_next  = S_WORD;
      end
      S_WORD: begin
        if (can_load) begin
          cmd.load_word = 1'b1;
          state_next    = sts.word_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= mbtc_pkg::ST_BAD_LEN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (load_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/modbus_tcp_read_holding_client.sv =====
// Modbus TCP function 3 client. An item that yields no result is accepted, then
// evaluated in the evaluate state of the controller. A request holds the input
// off while its 12 request bytes go out, one request byte per cycle while the
// output register drains; the first byte loads after the evaluate state. Each
// register word takes a read of the single registered RAM port, then a load.
// Synchronous active-high reset clears control state; no clearing pass.
module modbus_tcp_read_holding_client #(
  parameter int MAX_REGS = mbtc_pkg::MAX_REGS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mbtc_req_if.sink   in_ch,
  mbtc_res_if.source out_ch
);

  mbtc_pkg::cmd_t cmd;
  mbtc_pkg::sts_t sts;

  mbtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbtc_datapath #(.MAX_REGS(MAX_REGS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (in_ch.opcode),
    .unit_id       (in_ch.unit_id),
    .start_address (in_ch.start_address),
    .reg_count     (in_ch.reg_count),
    .rx_byte       (in_ch.rx_byte),
    .kind          (out_ch.kind),
    .tx_byte       (out_ch.tx_byte),
    .reg_index     (out_ch.reg_index),
    .reg_value     (out_ch.reg_value),
    .status        (out_ch.status),
    .last          (out_ch.last)
  );

  // one item in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while previous item still in work");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == mbtc_pkg::KIND_FAIL) |-> out_ch.last)
    else $error("failure status not marked last");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == mbtc_pkg::KIND_TX) |->
      (out_ch.reg_value == 16'd0 && out_ch.status == 2'd0 && out_ch.reg_index == 4'd0))
    else $error("request byte carries stray fields");

  a_no_load_while_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !(cmd.load_req || cmd.load_fail || cmd.load_word))
    else $error("result loaded while idle");

endmodule

// ===== bench/modbus_tcp_read_holding_client_test.sv =====
// Self-checking bench for the Modbus TCP function 3 client: drives requests and
// reply bytes, predicts every request byte, register word and failure status.
// Depends on mbtc_pkg, mbtc_req_if, mbtc_res_if and the client RTL.
module modbus_tcp_read_holding_client_test;

  localparam int BODY_MAX    = 1 + 2 * mbtc_pkg::MAX_REGS_DEF;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_GAP     = 8;
  localparam logic [7:0] FUNC_EXCEPTION = mbtc_pkg::FUNC_READ_HOLD | 8'h80;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  unit_id;
    logic [15:0] start_address;
    logic [4:0]  reg_count;
    logic [7:0]  rx_byte;
  } mb_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic [1:0]  status;
    logic        last;
  } mb_result_t;

  typedef enum int {
    RP_GOOD,
    RP_BAD_TID,
    RP_BAD_FUNC,
    RP_BAD_BYTECOUNT,
    RP_ODD_LENGTH,
    RP_BAD_LENGTH,
    RP_CUT_SHORT
  } reply_mode_e;

  logic clk;
  logic rst;

  mbtc_req_if req_ch ();
  mbtc_res_if res_ch ();

  modbus_tcp_read_holding_client DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // client state as the bench tracks it
  logic [15:0] next_tid;
  logic [15:0] pend_tid;
  logic [4:0]  pend_count;
  bit          pend_reply;
  int          rx_pos;
  logic [7:0]  hdr_bytes [mbtc_pkg::HDR_LEN];
  logic [7:0]  body_bytes [BODY_MAX];

  mb_result_t  expected_results [$];
  logic [7:0]  reply_bytes [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int errors       = 0;
  int useful_items = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- prediction
  function automatic void push_result(input logic [1:0] kind, input logic [7:0] tx,
                                      input logic [3:0] idx, input logic [15:0] val,
                                      input logic [1:0] st, input logic last);
    mb_result_t r;
    r = '{kind, tx, idx, val, st, last};
    expected_results.push_back(r);
  endfunction

  function automatic void push_failure(input logic [1:0] code);
    pend_reply = 1'b0;
    rx_pos = 0;
    push_result(mbtc_pkg::KIND_FAIL, '0, '0, '0, code, 1'b1);
  endfunction

  // length field of the header counts unit and function too
  function automatic int framed_body_len();
    return int'({hdr_bytes[4], hdr_bytes[5]}) - 2;
  endfunction

  function automatic void predict_item(input mb_item_t it);
    logic [7:0] frame [mbtc_pkg::REQ_LEN];
    int blen;
    int bpos;
    int n;
    int i;
    if (it.opcode == mbtc_pkg::OP_REQUEST) begin
      frame = '{next_tid[15:8], next_tid[7:0], 8'h00, 8'h00, 8'h00,
                mbtc_pkg::MBAP_LEN_LO, it.unit_id, mbtc_pkg::FUNC_READ_HOLD,
                it.start_address[15:8], it.start_address[7:0], 8'h00,
                {3'b000, it.reg_count}};
      for (i = 0; i < mbtc_pkg::REQ_LEN; i++)
        push_result(mbtc_pkg::KIND_TX, frame[i], '0, '0, '0,
                    i == mbtc_pkg::REQ_LEN - 1);
      pend_tid   = next_tid;
      next_tid   = next_tid + 16'd1;
      pend_count = it.reg_count;
      pend_reply = 1'b1;
      rx_pos     = 0;
      return;
    end
    if (!pend_reply)
      return;
    if (rx_pos < mbtc_pkg::HDR_LEN) begin
      hdr_bytes[rx_pos] = it.rx_byte;
      rx_pos++;
      if (rx_pos == mbtc_pkg::HDR_LEN) begin
        blen = framed_body_len();
        if (blen < 1 || blen > BODY_MAX)
          push_failure(mbtc_pkg::ST_BAD_LEN);
      end
      return;
    end
    blen = framed_body_len();
    bpos = rx_pos - mbtc_pkg::HDR_LEN;
    n = int'(pend_count);
    if (blen < 1 || blen > BODY_MAX || bpos >= blen) begin
      push_failure(mbtc_pkg::ST_BAD_LEN);
      return;
    end
    body_bytes[bpos] = it.rx_byte;
    rx_pos++;
    if (bpos + 1 < blen)
      return;
    if ({hdr_bytes[0], hdr_bytes[1]} != pend_tid) begin
      push_failure(mbtc_pkg::ST_TID);
    end else if (hdr_bytes[7] != mbtc_pkg::FUNC_READ_HOLD) begin
      push_failure(mbtc_pkg::ST_FUNC);
    end else if (int'(body_bytes[0]) != 2 * n || blen != 1 + 2 * n ||
                 n > mbtc_pkg::RUN_LIMIT) begin
      push_failure(mbtc_pkg::ST_COUNT);
    end else begin
      pend_reply = 1'b0;
      rx_pos = 0;
      for (i = 0; i < n; i++)
        push_result(mbtc_pkg::KIND_WORD, '0, 4'(i),
                    {body_bytes[1 + 2 * i], body_bytes[2 + 2 * i]}, '0, i + 1 == n);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic mb_item_t make_request(input logic [7:0] unit, input logic [15:0] addr,
                                            input logic [4:0] cnt);
    mb_item_t it;
    it.opcode        = mbtc_pkg::OP_REQUEST;
    it.unit_id       = unit;
    it.start_address = addr;
    it.reg_count     = cnt;
    it.rx_byte       = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic mb_item_t make_rx(input logic [7:0] b);
    mb_item_t it;
    it.opcode        = mbtc_pkg::OP_RX_BYTE;
    it.unit_id       = 8'($urandom_range(255));
    it.start_address = 16'($urandom_range(65535));
    it.reg_count     = 5'($urandom_range(31));
    it.rx_byte       = b;
    return it;
  endfunction

  function automatic logic [7:0] data_octet();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Reply to the pending request, corrupted as the mode says. A forced length
  // (>= 0) overrides the header length field.
  function automatic void build_reply(input reply_mode_e mode, input int forced_len);
    int n;
    int blen;
    int keep;
    int i;
    logic [15:0] tid;
    logic [15:0] lenf;
    logic [7:0]  func;
    logic [7:0]  bcount;
    n      = int'(pend_count);
    tid    = pend_tid;
    func   = mbtc_pkg::FUNC_READ_HOLD;
    blen   = 1 + 2 * n;
    bcount = 8'(2 * n);
    case (mode)
      RP_BAD_TID: tid = pend_tid ^ 16'($urandom_range(1, 65535));
      RP_BAD_FUNC: begin
        func = $urandom_range(1) ? FUNC_EXCEPTION : 8'($urandom_range(255));
        if (func == mbtc_pkg::FUNC_READ_HOLD)
          func = FUNC_EXCEPTION;
      end
      RP_BAD_BYTECOUNT: begin
        bcount = 8'($urandom_range(255));
        if (bcount == 8'(2 * n))
          bcount = bcount ^ 8'h01;
      end
      RP_ODD_LENGTH: begin
        blen = $urandom_range(1, BODY_MAX);
        if (blen == 1 + 2 * n)
          blen = (blen == 1) ? 2 : blen - 1;
        if ($urandom_range(1))
          bcount = 8'($urandom_range(255));
      end
      default: ;
    endcase
    lenf = 16'(blen + 2);
    if (forced_len >= 0) begin
      lenf = 16'(forced_len);
    end else if (mode == RP_BAD_LENGTH) begin
      case ($urandom_range(3))
        0:       lenf = 16'($urandom_range(2));
        1:       lenf = 16'(BODY_MAX + 3);
        2:       lenf = 16'($urandom_range(BODY_MAX + 3, 65535));
        default: lenf = 16'hFFFF;
      endcase
    end
    reply_bytes.delete();
    reply_bytes.push_back(tid[15:8]);
    reply_bytes.push_back(tid[7:0]);
    // protocol id is not checked by the client
    reply_bytes.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'h00);
    reply_bytes.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'h00);
    reply_bytes.push_back(lenf[15:8]);
    reply_bytes.push_back(lenf[7:0]);
    reply_bytes.push_back(8'($urandom_range(255)));
    reply_bytes.push_back(func);
    if (mode != RP_BAD_LENGTH) begin
      reply_bytes.push_back(bcount);
      for (i = 1; i < blen; i++)
        reply_bytes.push_back(data_octet());
    end
    if (mode == RP_CUT_SHORT) begin
      keep = $urandom_range(reply_bytes.size() - 1);
      while (reply_bytes.size() > keep)
        void'(reply_bytes.pop_back());
    end
  endfunction

  task automatic sender_gap();
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < tx_idle_pct)
      n++;
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // valid stays high on return unless a sender gap drops it, so back-to-back items need no re-raise
  task automatic send_item(input mb_item_t it);
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= it.opcode;
    req_ch.unit_id       <= it.unit_id;
    req_ch.start_address <= it.start_address;
    req_ch.reg_count     <= it.reg_count;
    req_ch.rx_byte       <= it.rx_byte;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (it.opcode == mbtc_pkg::OP_REQUEST || pend_reply)
      useful_items++;
    predict_item(it);
    sender_gap();
  endtask

  task automatic send_reply();
    int i;
    for (i = 0; i < reply_bytes.size(); i++)
      send_item(make_rx(reply_bytes[i]));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking
  initial begin : result_check
    mb_result_t got;
    mb_result_t want;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got = {res_ch.kind, res_ch.tx_byte, res_ch.reg_index, res_ch.reg_value,
               res_ch.status, res_ch.last};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result %0d: kind %0d tx %02h idx %0d value %04h st %0d last %0d",
                     results_seen, got.kind, got.tx_byte, got.reg_index, got.reg_value,
                     got.status, got.last);
        end else begin
          want = expected_results.pop_front();
          if (want.kind == mbtc_pkg::KIND_FAIL)
            status_seen[want.status]++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"result %0d mismatch: expected kind %0d tx %02h idx %0d value %04h",
                        " st %0d last %0d, got kind %0d tx %02h idx %0d value %04h",
                        " st %0d last %0d"}, results_seen,
                       want.kind, want.tx_byte, want.reg_index, want.reg_value,
                       want.status, want.last, got.kind, got.tx_byte, got.reg_index,
                       got.reg_value, got.status, got.last);
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_idle_bytes();
    send_item(make_rx(8'h00));
    send_item(make_rx(8'hFF));
    drain_results();
  endtask

  // extreme request, abandoned mid-header by a count 0 request, then a
  // zero-word reply and a byte after the block went idle
  task automatic test_abandon_and_zero_reply();
    send_item(make_request(8'hFF, 16'hFFFF, 5'd31));
    build_reply(RP_GOOD, -1);
    repeat (3) begin
      send_item(make_rx(reply_bytes[0]));
      void'(reply_bytes.pop_front());
    end
    send_item(make_request(8'h00, 16'h0000, 5'd0));
    build_reply(RP_GOOD, -1);
    send_reply();
    send_item(make_rx(8'h5A));
    drain_results();
  endtask

  task automatic test_bad_length();
    send_item(make_request(8'($urandom_range(255)), 16'($urandom_range(65535)), 5'd1));
    build_reply(RP_BAD_LENGTH, BODY_MAX + 3);
    send_reply();
    drain_results();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int goal;
    int r;
    int cnt;
    reply_mode_e mode;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    goal = useful_items + n_items;
    while (useful_items < goal) begin
      if ($urandom_range(99) < 6)
        repeat ($urandom_range(1, 3)) send_item(make_rx(8'($urandom_range(255))));
      r = $urandom_range(99);
      if (r < 12)      cnt = 16;
      else if (r < 22) cnt = $urandom_range(1) ? 0 : $urandom_range(17, 31);
      else if (r < 60) cnt = $urandom_range(1, 3);
      else             cnt = $urandom_range(1, 15);
      send_item(make_request(8'($urandom_range(255)), 16'($urandom_range(65535)), 5'(cnt)));
      r = $urandom_range(99);
      if (r < 40)      mode = RP_GOOD;
      else if (r < 50) mode = RP_BAD_TID;
      else if (r < 60) mode = RP_BAD_FUNC;
      else if (r < 70) mode = RP_BAD_BYTECOUNT;
      else if (r < 80) mode = RP_ODD_LENGTH;
      else if (r < 90) mode = RP_BAD_LENGTH;
      else             mode = RP_CUT_SHORT;
      build_reply(mode, -1);
      send_reply();
    end
    drain_results();
  endtask

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = mbtc_pkg::OP_REQUEST;
    req_ch.unit_id       = '0;
    req_ch.start_address = '0;
    req_ch.reg_count     = '0;
    req_ch.rx_byte       = '0;
    next_tid   = 16'd1;
    pend_tid   = '0;
    pend_count = '0;
    pend_reply = 1'b0;
    rx_pos     = 0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    foreach (body_bytes[i]) body_bytes[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_abandon_and_zero_reply();
    test_bad_length();
    test_random_traffic(0, 0, 120);
    test_random_traffic(58, 0, 120);
    test_random_traffic(0, 58, 120);
    test_random_traffic(24, 24, 120);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d accepted items and %0d results over idle/stall phases,",
             useful_items, results_seen);
    $display("abandoned and zero-word replies; failures: bad length %0d, tid %0d, %s",
             status_seen[mbtc_pkg::ST_BAD_LEN], status_seen[mbtc_pkg::ST_TID],
             $sformatf("function %0d, byte count %0d; errors %0d.",
                       status_seen[mbtc_pkg::ST_FUNC], status_seen[mbtc_pkg::ST_COUNT],
                       errors));
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mbtc_pkg.sv
hw/rtl/mbtc_req_if.sv
hw/rtl/mbtc_res_if.sv
hw/rtl/mbtc_datapath.sv
hw/rtl/mbtc_ctrl.sv
hw/rtl/modbus_tcp_read_holding_client.sv
bench/modbus_tcp_read_holding_client_test.sv
